// ----- rtl/core/timestamped_event_recorder_player_core_macros.svh -----
// assertion macros for the event recorder and player core
// used by the top level only; expects clk and rst in scope
`ifndef TIMESTAMPED_EVENT_RECORDER_PLAYER_CORE_MACROS_SVH
`define TIMESTAMPED_EVENT_RECORDER_PLAYER_CORE_MACROS_SVH

// same-cycle implication
`define TSERP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tserp assertion failed");

// next-cycle implication
`define TSERP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tserp assertion failed");

`endif

// ----- rtl/core/tserp_pkg.sv -----
// shared types, codes and defaults for the event recorder and player core
// no dependencies
`default_nettype none

package tserp_pkg;

  localparam int TRACKS_DEF              = 8;
  localparam int MARKS_PER_TRACK_DEF     = 64;
  localparam int MAX_REPLAY_PER_TICK_DEF = 63;

  localparam int DATA_W = 64;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_MARK   = 2'd1;
  localparam logic [1:0] FUNC_UNMARK = 2'd2;
  localparam logic [1:0] FUNC_START  = 2'd3;

  localparam logic KIND_MARK   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  localparam logic REG_PLAY_DURATION  = 1'b0;
  localparam logic REG_RECORDING_MODE = 1'b1;

  typedef struct packed {
    logic        item_kind;
    logic [2:0]  mark_track;
    logic [5:0]  mark_index;
    logic [31:0] mark_time;
    logic [31:0] mark_length;
    logic        finished;
    logic [1:0]  error_code;
    logic        last;
  } res_t;

  typedef struct packed {
    logic emit;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/tserp_mark_mem.sv -----
// mark store: time in the low word, length in the high word
// one write port, one read port with registered data; uses tserp_pkg
`default_nettype none

module tserp_mark_mem #(
  parameter int DEPTH = tserp_pkg::TRACKS_DEF * tserp_pkg::MARKS_PER_TRACK_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               wa,
  input  logic [tserp_pkg::DATA_W-1:0] wd,
  input  logic                        re,
  input  logic [AW-1:0]               ra,
  output logic [tserp_pkg::DATA_W-1:0] rd
);

  logic [tserp_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tserp_ctrl.sv -----
// sequencer: per-track counts and cursors, start time, position, replay scan
// holds the mark store (tserp_mark_mem); uses tserp_pkg
`default_nettype none

module tserp_ctrl #(
  parameter int TRACKS              = tserp_pkg::TRACKS_DEF,
  parameter int MARKS_PER_TRACK     = tserp_pkg::MARKS_PER_TRACK_DEF,
  parameter int MAX_REPLAY_PER_TICK = tserp_pkg::MAX_REPLAY_PER_TICK_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [31:0]           in_now,
  input  logic [2:0]            in_sel,
  input  logic [31:0]           play_duration,
  input  logic                  recording_mode,
  input  logic                  out_free,
  output tserp_pkg::res_t       res,
  output tserp_pkg::ctrl_stat_t stat
);

  localparam int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int TCNT_W = $clog2(TRACKS + 1);
  localparam int CNT_W  = $clog2(MARKS_PER_TRACK + 1);
  localparam int DEPTH  = TRACKS * MARKS_PER_TRACK;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int N_W    = $clog2(MAX_REPLAY_PER_TICK + 1);
  localparam int TRKX_W = (TRK_W > 3) ? TRK_W : 3;
  localparam int IDXX_W = (CNT_W > 6) ? CNT_W : 6;

  localparam logic [AW-1:0]     MPT_A   = AW'(MARKS_PER_TRACK);
  localparam logic [CNT_W-1:0]  MPT_C   = CNT_W'(MARKS_PER_TRACK);
  localparam logic [TCNT_W-1:0] TRK_END = TCNT_W'(TRACKS);
  localparam logic [N_W-1:0]    N_END   = N_W'(MAX_REPLAY_PER_TICK);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_TICK_CHK  = 4'd1;
  localparam logic [3:0] S_TICK_EVAL = 4'd2;
  localparam logic [3:0] S_STATUS    = 4'd3;
  localparam logic [3:0] S_MARK      = 4'd4;
  localparam logic [3:0] S_UNMARK    = 4'd5;
  localparam logic [3:0] S_UN_EVAL   = 4'd6;

  logic [3:0]        state, state_next;
  logic [31:0]       start_time;
  logic [31:0]       cur_pos;
  logic [TCNT_W-1:0] t;
  logic [N_W-1:0]    n;
  logic [2:0]        sel_q;
  logic [CNT_W-1:0]  counts  [TRACKS];
  logic [CNT_W-1:0]  cursors [TRACKS];

  logic [TRK_W-1:0]  t_idx, sel_trk, ci;
  logic [TRKX_W-1:0] sel_ext, t_ext;
  logic [IDXX_W-1:0] cur_ext, cnt_ext, cm1_ext;
  logic [CNT_W-1:0]  cnt, cnt_m1, cur;
  logic              sel_ok, scan, fin, accept;
  logic              inc_t, inc_cur, inc_cnt;
  logic [31:0]       rd_time, rd_len, un_len;

  logic                        re, we;
  logic [AW-1:0]               ra, wa;
  logic [tserp_pkg::DATA_W-1:0] wd, rd;

  function automatic logic [AW-1:0] addr_of(input logic [TRK_W-1:0] trk,
                                            input logic [CNT_W-1:0] idx);
    addr_of = AW'(trk) * MPT_A + AW'(idx);
  endfunction

  tserp_mark_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk(clk),
    .we (we),
    .wa (wa),
    .wd (wd),
    .re (re),
    .ra (ra),
    .rd (rd)
  );

  assign t_idx   = t[TRK_W-1:0];
  assign sel_ext = TRKX_W'(sel_q);
  assign sel_trk = sel_ext[TRK_W-1:0];
  assign sel_ok  = (32'(sel_q) < 32'(TRACKS));
  assign scan    = (state == S_TICK_CHK) || (state == S_TICK_EVAL);
  assign ci      = scan ? t_idx : sel_trk;
  assign cnt     = counts[ci];
  assign cnt_m1  = cnt - CNT_W'(1);
  assign cur     = cursors[t_idx];
  assign t_ext   = TRKX_W'(t_idx);
  assign cur_ext = IDXX_W'(cur);
  assign cnt_ext = IDXX_W'(cnt);
  assign cm1_ext = IDXX_W'(cnt_m1);
  assign fin     = (cur_pos > play_duration);
  assign rd_time = rd[31:0];
  assign rd_len  = rd[63:32];
  assign un_len  = cur_pos - rd_time;
  assign accept  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    stat.emit  = 1'b0;
    re         = 1'b0;
    ra         = addr_of(t_idx, cur);
    we         = 1'b0;
    wa         = addr_of(sel_trk, cnt);
    wd         = {32'd0, cur_pos};
    inc_t      = 1'b0;
    inc_cur    = 1'b0;
    inc_cnt    = 1'b0;
    res.item_kind   = tserp_pkg::KIND_STATUS;
    res.mark_track  = 3'd0;
    res.mark_index  = 6'd0;
    res.mark_time   = 32'd0;
    res.mark_length = 32'd0;
    res.finished    = fin;
    res.error_code  = tserp_pkg::ERR_OK;
    res.last        = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_func)
            tserp_pkg::FUNC_TICK:   state_next = recording_mode ? S_STATUS : S_TICK_CHK;
            tserp_pkg::FUNC_MARK:   state_next = S_MARK;
            tserp_pkg::FUNC_UNMARK: state_next = S_UNMARK;
            default:                state_next = S_STATUS;
          endcase
        end
      end
      S_TICK_CHK: begin
        if ((t == TRK_END) || (n == N_END)) begin
          state_next = S_STATUS;
        end else if (cur < cnt) begin
          re         = 1'b1;
          state_next = S_TICK_EVAL;
        end else begin
          inc_t = 1'b1;
        end
      end
      S_TICK_EVAL: begin
        res.item_kind   = tserp_pkg::KIND_MARK;
        res.mark_track  = t_ext[2:0];
        res.mark_index  = cur_ext[5:0];
        res.mark_time   = rd_time;
        res.mark_length = rd_len;
        res.last        = 1'b0;
        if (rd_time > cur_pos) begin
          inc_t      = 1'b1;
          state_next = S_TICK_CHK;
        end else if (out_free) begin
          stat.emit  = 1'b1;
          inc_cur    = 1'b1;
          state_next = S_TICK_CHK;
        end
      end
      S_STATUS: begin
        res.mark_time = cur_pos;
        if (out_free) begin
          stat.emit  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MARK: begin
        res.mark_track = sel_q;
        if (!sel_ok || (cnt >= MPT_C)) begin
          res.error_code = tserp_pkg::ERR_FULL;
        end else begin
          res.mark_index = cnt_ext[5:0];
          res.mark_time  = cur_pos;
        end
        if (out_free) begin
          stat.emit  = 1'b1;
          we         = sel_ok && (cnt < MPT_C);
          inc_cnt    = we;
          state_next = S_IDLE;
        end
      end
      S_UNMARK: begin
        res.mark_track = sel_q;
        res.error_code = tserp_pkg::ERR_EMPTY;
        ra             = addr_of(sel_trk, cnt_m1);
        if (sel_ok && (cnt != '0)) begin
          re         = 1'b1;
          state_next = S_UN_EVAL;
        end else if (out_free) begin
          stat.emit  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_UN_EVAL: begin
        res.mark_track  = sel_q;
        res.mark_index  = cm1_ext[5:0];
        res.mark_time   = rd_time;
        res.mark_length = un_len;
        wa              = addr_of(sel_trk, cnt_m1);
        wd              = {un_len, rd_time};
        if (out_free) begin
          stat.emit  = 1'b1;
          we         = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      start_time <= '0;
      cur_pos    <= '0;
      t          <= '0;
      n          <= '0;
      sel_q      <= '0;
      for (int k = 0; k < TRACKS; k++) begin
        counts[k]  <= '0;
        cursors[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (accept) begin
        sel_q <= in_sel;
        t     <= '0;
        n     <= '0;
        if (in_func == tserp_pkg::FUNC_TICK) begin
          cur_pos <= in_now - start_time;
        end else if (in_func == tserp_pkg::FUNC_START) begin
          start_time <= in_now;
          cur_pos    <= '0;
        end
      end
      if (inc_t) begin
        t <= t + TCNT_W'(1);
      end
      if (inc_cur) begin
        cursors[t_idx] <= cur + CNT_W'(1);
        n              <= n + N_W'(1);
      end
      if (inc_cnt) begin
        counts[sel_trk] <= cnt + CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/timestamped_event_recorder_player_core.sv -----
// top level of the event recorder and player: register port, result register
// depends on tserp_pkg, tserp_ctrl, tserp_mark_mem and the macros header
//
//   channel  | direction | handshake         | payload
//   s_*      | request in| s_tvalid/s_tready | s_tuser func, s_tdata now_time, track_sel
//   m_*      | result out| m_tvalid/m_tready | m_tuser item_kind, m_tdata, m_tlast
//   apb      | config    | psel/penable      | paddr, pwdata, prdata, pready always high
//
// one request at a time; unmark reads the mark store first unless the track is empty
// tick: straight to status while recording, else a scan that skips tracks with no
//   pending mark and reads each replayed mark and the first one not yet due on a
//   track from the single read port; the scan stops after MAX_REPLAY_PER_TICK replays
// a stalled result register holds the sequencer in place
// synchronous reset clears counts, cursors, start time and position at once
`default_nettype none

module timestamped_event_recorder_player_core #(
  parameter int TRACKS              = tserp_pkg::TRACKS_DEF,
  parameter int MARKS_PER_TRACK     = tserp_pkg::MARKS_PER_TRACK_DEF,
  parameter int MAX_REPLAY_PER_TICK = tserp_pkg::MAX_REPLAY_PER_TICK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // now_time [31:0], track_sel [34:32], zero pad
  input  logic [1:0]  s_tuser,   // func [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // mark_track [2:0], mark_index [8:3], mark_time [40:9],
                                 // mark_length [72:41], finished [73], error_code [75:74]
  output logic [0:0]  m_tuser,   // item_kind [0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "timestamped_event_recorder_player_core_macros.svh"

  logic [31:0]           play_duration;
  logic                  recording_mode;
  logic                  out_free;
  tserp_pkg::res_t       res;
  tserp_pkg::res_t       out_q;
  tserp_pkg::ctrl_stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      play_duration  <= '0;
      recording_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == tserp_pkg::REG_PLAY_DURATION) begin
        play_duration <= pwdata;
      end else begin
        recording_mode <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == tserp_pkg::REG_RECORDING_MODE) begin
      prdata = {31'd0, recording_mode};
    end else begin
      prdata = play_duration;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  tserp_ctrl #(
    .TRACKS             (TRACKS),
    .MARKS_PER_TRACK    (MARKS_PER_TRACK),
    .MAX_REPLAY_PER_TICK(MAX_REPLAY_PER_TICK)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_func       (s_tuser),
    .in_now        (s_tdata[31:0]),
    .in_sel        (s_tdata[34:32]),
    .play_duration (play_duration),
    .recording_mode(recording_mode),
    .out_free      (out_free),
    .res           (res),
    .stat          (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit) begin
      out_q <= res;
    end
  end

  assign m_tdata = {4'd0, out_q.error_code, out_q.finished, out_q.mark_length,
                    out_q.mark_time, out_q.mark_index, out_q.mark_track};
  assign m_tuser = out_q.item_kind;
  assign m_tlast = out_q.last;

  // no result overwrites one still waiting
  `TSERP_ASSERT_NOW(a_no_overwrite, stat.emit && m_tvalid, m_tready)
  // one request in flight at a time
  `TSERP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // only the status result closes a request
  `TSERP_ASSERT_NOW(a_last_on_status, m_tvalid, m_tlast == (m_tuser[0] == tserp_pkg::KIND_STATUS))
  // no replay while recording
  `TSERP_ASSERT_NOW(a_no_replay_rec, stat.emit && (res.item_kind == tserp_pkg::KIND_MARK), !recording_mode)

endmodule

`default_nettype wire
